// ----- hdl/h3fd_pkg.sv -----
// ----------------------------------------------------------------------------
// h3fd_pkg
// Shared types and constants for the HTTP/3 frame deframer.
// ----------------------------------------------------------------------------
package h3fd_pkg;

    localparam int VARINT_W  = 62;  // QUIC varint value width
    localparam int BYTE_W    = 8;
    localparam int PREFIX_LO = 6;   // length prefix sits in bits [7:6]
    localparam int LEFT_W    = 3;   // continuation bytes still to read

    localparam int S_TDATA_W = 8;   // in_byte
    localparam int M_TDATA_W = 72;  // frame_kind_code, payload_byte, pad
    localparam int M_TUSER_W = 5;   // status, kind, has_byte

    typedef enum logic [1:0] {
        PH_TYPE0 = 2'd0,  // first byte of frame type
        PH_TYPE  = 2'd1,  // frame type continuation
        PH_LEN   = 2'd2,  // payload length varint
        PH_PAY   = 2'd3   // payload bytes
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TRUNC_HDR = 2'd1,
        ST_TRUNC_PAY = 2'd2,
        ST_RSVD      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_HEADERS = 2'd1,
        KIND_OTHER   = 2'd2,
        KIND_RSVD    = 2'd3
    } t_kind;

    localparam logic [VARINT_W-1:0] TYPE_DATA    = VARINT_W'(0);
    localparam logic [VARINT_W-1:0] TYPE_HEADERS = VARINT_W'(1);

    // continuation bytes that follow a varint first byte
    function automatic logic [LEFT_W-1:0] f_varint_left(input logic [1:0] prefix);
        logic [LEFT_W-1:0] left;
        unique case (prefix)
            2'd0:    left = 3'd0;
            2'd1:    left = 3'd1;
            2'd2:    left = 3'd3;
            default: left = 3'd7;
        endcase
        return left;
    endfunction

    function automatic t_kind f_class(input logic [VARINT_W-1:0] ftype);
        t_kind k;
        priority if (ftype == TYPE_DATA)    k = KIND_DATA;
        else if     (ftype == TYPE_HEADERS) k = KIND_HEADERS;
        else                                k = KIND_OTHER;
        return k;
    endfunction

endpackage

// ----- hdl/http3_frame_deframer_top.sv -----
// ----------------------------------------------------------------------------
// http3_frame_deframer_top
// Splits a byte stream into HTTP/3 frames and tags each payload byte.
// ----------------------------------------------------------------------------
// Takes one stream byte per transfer and emits at most one result per byte.
// Throughput is one byte per clock while the output is not stalled: a byte
// is registered on input, parsed by combinational varint/length logic, and its
// result lands in the output register. Header bytes produce no result,
// except on truncation; a zero-length frame yields one byteless end marker.
// tlast on the input marks the end of a stream buffer, after which the parser
// restarts at a frame type. Output tlast marks a frame end or a truncation.
module http3_frame_deframer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [h3fd_pkg::S_TDATA_W-1:0] i_s_tdata,  // [7:0] in_byte
    input  logic                          i_s_tlast,  // buffer_end
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [h3fd_pkg::M_TDATA_W-1:0] o_m_tdata,  // [61:0] frame_kind_code,
                                                       // [69:62] payload_byte, pad
    output logic [h3fd_pkg::M_TUSER_W-1:0] o_m_tuser,  // [1:0] status, [3:2] kind,
                                                       // [4] has_byte
    output logic                          o_m_tlast   // frame_end
);
    import h3fd_pkg::*;

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    // parser state
    t_phase              r_phase, n_phase;
    logic [LEFT_W-1:0]   r_left, n_left;
    logic [VARINT_W-1:0] r_acc, n_acc;
    logic [VARINT_W-1:0] r_type, n_type;
    logic [VARINT_W-1:0] r_pay_left, n_pay_left;

    // output register
    logic                r_out_valid;
    t_status             r_out_status;
    t_kind               r_out_kind;
    logic [VARINT_W-1:0] r_out_code;
    logic                r_out_has_byte;
    logic [BYTE_W-1:0]   r_out_byte;
    logic                r_out_end;

    logic advance;
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    // varint decode of the byte in the input register
    logic [1:0]          prefix;
    logic                first_done, next_done, len_done, len_zero, pay_last;
    logic [LEFT_W-1:0]   first_left;
    logic [VARINT_W-1:0] first_val, acc_shift, len_val;

    assign prefix     = r_in_byte[BYTE_W-1:PREFIX_LO];
    assign first_left = f_varint_left(prefix);
    assign first_done = (prefix == 2'd0);
    assign first_val  = {{(VARINT_W-PREFIX_LO){1'b0}}, r_in_byte[PREFIX_LO-1:0]};
    assign acc_shift  = {r_acc[VARINT_W-BYTE_W-1:0], r_in_byte};
    assign next_done  = (r_left == LEFT_W'(1));
    assign len_done   = (r_left == '0) ? first_done : next_done;
    assign len_val    = (r_left == '0) ? first_val : acc_shift;
    assign len_zero   = (len_val == '0);
    assign pay_last   = (r_pay_left == VARINT_W'(1));

    // phase after this byte, before any buffer-end restart
    t_phase step_phase;
    always_comb begin
        step_phase = r_phase;
        unique case (r_phase)
            PH_TYPE0: step_phase = first_done ? PH_LEN : PH_TYPE;
            PH_TYPE:  if (next_done) step_phase = PH_LEN;
            PH_LEN:   if (len_done) step_phase = len_zero ? PH_TYPE0 : PH_PAY;
            PH_PAY:   if (pay_last) step_phase = PH_TYPE0;
        endcase
    end

    // next state
    always_comb begin
        n_phase    = step_phase;
        n_left     = r_left;
        n_acc      = r_acc;
        n_type     = r_type;
        n_pay_left = r_pay_left;
        unique case (r_phase)
            PH_TYPE0: begin
                n_acc = first_val;
                if (first_done) begin
                    n_type = first_val;
                    n_left = '0;
                end else begin
                    n_left = first_left;
                end
            end
            PH_TYPE: begin
                n_acc  = acc_shift;
                n_left = r_left - LEFT_W'(1);
                if (next_done) begin
                    n_type = acc_shift;
                end
            end
            PH_LEN: begin
                n_acc  = len_val;
                n_left = (r_left == '0) ? first_left : r_left - LEFT_W'(1);
                if (len_done) begin
                    n_pay_left = len_val;
                end
            end
            PH_PAY: begin
                n_pay_left = r_pay_left - VARINT_W'(1);
            end
        endcase
        if (r_in_last) begin
            n_phase    = PH_TYPE0;
            n_left     = '0;
            n_acc      = '0;
            n_type     = '0;
            n_pay_left = '0;
        end
    end

    // result of this byte
    logic                emit;
    t_status             res_status;
    t_kind               res_kind;
    logic [VARINT_W-1:0] res_code;
    logic                res_has_byte;
    logic [BYTE_W-1:0]   res_byte;
    logic                res_end;
    logic [VARINT_W-1:0] type_now;

    // frame type as it stands after this byte
    assign type_now = (r_phase == PH_TYPE0 && first_done) ? first_val :
                      (r_phase == PH_TYPE && next_done)   ? acc_shift : r_type;

    always_comb begin
        emit         = 1'b0;
        res_status   = ST_OK;
        res_kind     = f_class(type_now);
        res_code     = type_now;
        res_has_byte = 1'b0;
        res_byte     = '0;
        res_end      = 1'b1;
        if (r_phase == PH_PAY) begin
            emit         = 1'b1;
            res_has_byte = 1'b1;
            res_byte     = r_in_byte;
            if (!pay_last) begin
                res_status = r_in_last ? ST_TRUNC_PAY : ST_OK;
                res_end    = r_in_last;
            end
        end else if (r_phase == PH_LEN && len_done && len_zero) begin
            emit = 1'b1;
        end else if (r_in_last && step_phase != PH_TYPE0) begin
            // buffer ran out mid-frame
            emit = 1'b1;
            priority case (step_phase)
                PH_TYPE: begin
                    res_status = ST_TRUNC_HDR;
                    res_kind   = KIND_DATA;
                    res_code   = '0;
                end
                PH_LEN:  res_status = ST_TRUNC_HDR;
                default: res_status = ST_TRUNC_PAY;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_TYPE0;
            r_left      <= '0;
            r_acc       <= '0;
            r_type      <= '0;
            r_pay_left  <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_phase    <= n_phase;
                r_left     <= n_left;
                r_acc      <= n_acc;
                r_type     <= n_type;
                r_pay_left <= n_pay_left;
            end
            if (advance && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
        if (advance && emit) begin
            r_out_status   <= res_status;
            r_out_kind     <= res_kind;
            r_out_code     <= res_code;
            r_out_has_byte <= res_has_byte;
            r_out_byte     <= res_byte;
            r_out_end      <= res_end;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_TDATA_W-VARINT_W-BYTE_W){1'b0}}, r_out_byte, r_out_code};
    assign o_m_tuser  = {r_out_has_byte, r_out_kind, r_out_status};
    assign o_m_tlast  = r_out_end;

endmodule

// ----- hdl/h3fd_checker.sv -----
// ----------------------------------------------------------------------------
// h3fd_checker
// Port-level checks for the HTTP/3 frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
module h3fd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic [h3fd_pkg::S_TDATA_W-1:0] i_s_tdata,
    input logic                           i_s_tlast,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [h3fd_pkg::M_TDATA_W-1:0] o_m_tdata,
    input logic [h3fd_pkg::M_TUSER_W-1:0] o_m_tuser,
    input logic                           o_m_tlast
);
    import h3fd_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("output changed while stalled");

    // byteless results only ever close a frame, and carry a zero byte
    a_byteless_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[4] |-> o_m_tlast && o_m_tdata[69:62] == '0)
        else $error("byteless result not a frame end");

    // truncation ends the frame; a header truncation has no byte
    a_trunc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1:0] != ST_OK |-> o_m_tlast
            && (o_m_tuser[1:0] != ST_TRUNC_HDR || !o_m_tuser[4]))
        else $error("bad truncation result");

    // class agrees with the frame type code
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser[3:2] == KIND_DATA && o_m_tdata[61:0] == TYPE_DATA)
            || (o_m_tuser[3:2] == KIND_HEADERS && o_m_tdata[61:0] == TYPE_HEADERS)
            || (o_m_tuser[3:2] == KIND_OTHER && o_m_tdata[61:0] != TYPE_DATA
                && o_m_tdata[61:0] != TYPE_HEADERS))
        else $error("kind does not match frame type");

endmodule

bind http3_frame_deframer_top h3fd_checker u_h3fd_checker (.*);
